FILE: hw/rtl/cpa_pkg.sv
package cpa_pkg;

  // field widths
  localparam int unsigned PosW  = 32;
  localparam int unsigned VelW  = 21;
  localparam int unsigned TimeW = 40;
  localparam int unsigned DistW = 41;

  // stream widths
  localparam int unsigned InW  = 336;
  localparam int unsigned OutW = 88;

  // iterative units
  localparam int unsigned DivSteps  = 40;
  localparam int unsigned SqrtSteps = 64;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // one stage of the time quotient
  typedef struct packed {
    logic               go;
    logic               ovf;
    logic               dvg;
    logic [39:0]        mlo;
    logic [45:0]        rem;
    logic [39:0]        quo;
    logic [44:0]        d2;
    logic signed [63:0] dpx;
    logic signed [63:0] dpy;
    logic signed [21:0] dvx;
    logic signed [21:0] dvy;
  } div_t;

  // one stage of the distance square root
  typedef struct packed {
    logic [TimeW-1:0] t;
    logic             dvg;
    logic [127:0]     rad;
    logic [65:0]      rem;
    logic [63:0]      root;
  } sqrt_t;

  // restoring division, one quotient bit
  function automatic div_t div_step(div_t s);
    div_t        r;
    logic [46:0] sh;
    logic        qb;
    r  = s;
    sh = {s.rem, s.mlo[39]};
    qb = (sh >= {2'b00, s.d2});
    if (qb) begin
      sh = sh - {2'b00, s.d2};
    end
    r.rem = sh[45:0];
    r.mlo = {s.mlo[38:0], 1'b0};
    r.quo = {s.quo[38:0], qb};
    return r;
  endfunction

  // digit recurrence square root, one root bit
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       r;
    logic [67:0] rm;
    logic [67:0] trial;
    r     = s;
    rm    = {s.rem, s.rad[127:126]};
    trial = {2'b00, s.root, 2'b01};
    if (rm >= trial) begin
      rm     = rm - trial;
      r.root = {s.root[62:0], 1'b1};
    end else begin
      r.root = {s.root[62:0], 1'b0};
    end
    r.rem = rm[65:0];
    r.rad = {s.rad[125:0], 2'b00};
    return r;
  endfunction

endpackage

FILE: hw/rtl/closest_point_of_approach_unit.sv
// Closest point of approach of two 2D constant-velocity tracks. One track pair is accepted
// per clock while tready is high, and its result passes through 5 front stages, the divider
// entry and 40 quotient stages, 6 distance stages, the root entry and 64 square-root stages,
// and the output register; the depth is set by the bit-per-stage divider for the approach
// time and the bit-per-stage square root for the distance. tready falls only while
// a finished result waits at the output, and then the whole pipeline holds. Time is
// rounded to nearest and saturates at 2^40-1, distance rounds to nearest and saturates at
// 2^41-1; diverging (tuser) is set when the closest approach lies strictly in the past.
module closest_point_of_approach_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_update_time,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_update_time, ref_time
  input  logic [cpa_pkg::InW-1:0]   s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // approach_time, approach_distance
  output logic [cpa_pkg::OutW-1:0]  m_axis_tdata_o,
  // diverging
  output logic                      m_axis_tuser_o
);

  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // input fields
  logic signed [31:0] apx, apy, bpx, bpy;
  logic signed [20:0] avx, avy, bvx, bvy;
  logic [39:0]        at, bt, rt;
  assign apx = s_axis_tdata_i[31:0];
  assign apy = s_axis_tdata_i[63:32];
  assign avx = s_axis_tdata_i[84:64];
  assign avy = s_axis_tdata_i[105:85];
  assign at  = s_axis_tdata_i[145:106];
  assign bpx = s_axis_tdata_i[177:146];
  assign bpy = s_axis_tdata_i[209:178];
  assign bvx = s_axis_tdata_i[230:210];
  assign bvy = s_axis_tdata_i[251:231];
  assign bt  = s_axis_tdata_i[291:252];
  assign rt  = s_axis_tdata_i[331:292];

  // valid bits of the front and back stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic vt_q, vm_q, va_q, vb_q, vc_q, vs_q, vo_q;
  logic [cpa_pkg::DivSteps:0]  dv_v_q;
  logic [cpa_pkg::SqrtSteps:0] sq_v_q;

  // stage 1: ages
  logic signed [40:0] s1_dta_q, s1_dtb_q;
  logic signed [31:0] s1_apx_q, s1_apy_q, s1_bpx_q, s1_bpy_q;
  logic signed [20:0] s1_avx_q, s1_avy_q, s1_bvx_q, s1_bvy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dta_q <= $signed({1'b0, rt}) - $signed({1'b0, at});
      s1_dtb_q <= $signed({1'b0, rt}) - $signed({1'b0, bt});
      s1_apx_q <= apx;
      s1_apy_q <= apy;
      s1_bpx_q <= bpx;
      s1_bpy_q <= bpy;
      s1_avx_q <= avx;
      s1_avy_q <= avy;
      s1_bvx_q <= bvx;
      s1_bvy_q <= bvy;
    end
  end

  // stage 2: velocity times age, position difference
  logic signed [61:0] s2_pax_q, s2_pay_q, s2_pbx_q, s2_pby_q;
  logic signed [42:0] s2_pdx_q, s2_pdy_q;
  logic signed [21:0] s2_dvx_q, s2_dvy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pax_q <= s1_avx_q * s1_dta_q;
      s2_pay_q <= s1_avy_q * s1_dta_q;
      s2_pbx_q <= s1_bvx_q * s1_dtb_q;
      s2_pby_q <= s1_bvy_q * s1_dtb_q;
      s2_pdx_q <= $signed({s1_apx_q[31], s1_apx_q, 10'b0})
                - $signed({s1_bpx_q[31], s1_bpx_q, 10'b0});
      s2_pdy_q <= $signed({s1_apy_q[31], s1_apy_q, 10'b0})
                - $signed({s1_bpy_q[31], s1_bpy_q, 10'b0});
      s2_dvx_q <= $signed({s1_avx_q[20], s1_avx_q}) - $signed({s1_bvx_q[20], s1_bvx_q});
      s2_dvy_q <= $signed({s1_avy_q[20], s1_avy_q}) - $signed({s1_bvy_q[20], s1_bvy_q});
    end
  end

  // stage 3: relative position
  logic signed [63:0] s3_dpx_q, s3_dpy_q;
  logic signed [21:0] s3_dvx_q, s3_dvy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dpx_q <= $signed({{21{s2_pdx_q[42]}}, s2_pdx_q})
                + $signed({{2{s2_pax_q[61]}}, s2_pax_q})
                - $signed({{2{s2_pbx_q[61]}}, s2_pbx_q});
      s3_dpy_q <= $signed({{21{s2_pdy_q[42]}}, s2_pdy_q})
                + $signed({{2{s2_pay_q[61]}}, s2_pay_q})
                - $signed({{2{s2_pby_q[61]}}, s2_pby_q});
      s3_dvx_q <= s2_dvx_q;
      s3_dvy_q <= s2_dvy_q;
    end
  end

  // stage 4: dot product halves, speed squared
  logic signed [54:0] s4_xl_q, s4_yl_q;
  logic signed [53:0] s4_xh_q, s4_yh_q;
  logic signed [43:0] sqx, sqy;
  logic [44:0]        s4_dv2_q;
  logic signed [63:0] s4_dpx_q, s4_dpy_q;
  logic signed [21:0] s4_dvx_q, s4_dvy_q;

  assign sqx = s3_dvx_q * s3_dvx_q;
  assign sqy = s3_dvy_q * s3_dvy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_xl_q  <= $signed({1'b0, s3_dpx_q[31:0]}) * s3_dvx_q;
      s4_yl_q  <= $signed({1'b0, s3_dpy_q[31:0]}) * s3_dvy_q;
      s4_xh_q  <= $signed(s3_dpx_q[63:32]) * s3_dvx_q;
      s4_yh_q  <= $signed(s3_dpy_q[63:32]) * s3_dvy_q;
      s4_dv2_q <= {1'b0, sqx[43:0]} + {1'b0, sqy[43:0]};
      s4_dpx_q <= s3_dpx_q;
      s4_dpy_q <= s3_dpy_q;
      s4_dvx_q <= s3_dvx_q;
      s4_dvy_q <= s3_dvy_q;
    end
  end

  // stage 5: dot product
  logic signed [87:0] s5_dot_q;
  logic [44:0]        s5_dv2_q;
  logic signed [63:0] s5_dpx_q, s5_dpy_q;
  logic signed [21:0] s5_dvx_q, s5_dvy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_dot_q <= $signed({{2{s4_xh_q[53]}}, s4_xh_q, 32'b0})
                + $signed({{33{s4_xl_q[54]}}, s4_xl_q})
                + $signed({{2{s4_yh_q[53]}}, s4_yh_q, 32'b0})
                + $signed({{33{s4_yl_q[54]}}, s4_yl_q});
      s5_dv2_q <= s4_dv2_q;
      s5_dpx_q <= s4_dpx_q;
      s5_dpy_q <= s4_dpy_q;
      s5_dvx_q <= s4_dvx_q;
      s5_dvy_q <= s4_dvy_q;
    end
  end

  // division entry: rounded dividend, overflow check, case flags
  logic [87:0]     mneg, mnum;
  logic [44:0]     d2;
  logic            neg, par;
  cpa_pkg::div_t   div_in;

  assign neg  = s5_dot_q[87];
  assign par  = (s5_dv2_q == '0);
  assign mneg = 88'd0 - s5_dot_q;
  assign mnum = {mneg[86:0], 1'b0} + {43'd0, s5_dv2_q};
  assign d2   = {s5_dv2_q[43:0], 1'b0};

  always_comb begin
    div_in     = '0;
    div_in.go  = !par && neg;
    div_in.dvg = !par && !neg && (s5_dot_q != '0);
    div_in.ovf = (mnum >= {3'b000, d2, 40'd0});
    div_in.rem = mnum[85:40];
    div_in.mlo = mnum[39:0];
    div_in.d2  = d2;
    div_in.dpx = s5_dpx_q;
    div_in.dpy = s5_dpy_q;
    div_in.dvx = s5_dvx_q;
    div_in.dvy = s5_dvy_q;
  end

  // quotient pipeline, one bit per stage
  cpa_pkg::div_t div_q [cpa_pkg::DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_in;
    end
  end

  for (genvar k = 1; k <= cpa_pkg::DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k] <= cpa_pkg::div_step(div_q[k-1]);
      end
    end
  end

  // approach time select
  logic [39:0]        t_q;
  logic               t_go_q, t_ovf_q, t_dvg_q;
  logic signed [63:0] t_dpx_q, t_dpy_q;
  logic signed [21:0] t_dvx_q, t_dvy_q;
  cpa_pkg::div_t      dlast;

  assign dlast = div_q[cpa_pkg::DivSteps];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!dlast.go) begin
        t_q <= '0;
      end else if (dlast.ovf) begin
        t_q <= cpa_pkg::TimeMax;
      end else begin
        t_q <= dlast.quo;
      end
      t_go_q  <= dlast.go;
      t_ovf_q <= dlast.ovf;
      t_dvg_q <= dlast.dvg;
      t_dpx_q <= dlast.dpx;
      t_dpy_q <= dlast.dpy;
      t_dvx_q <= dlast.dvx;
      t_dvy_q <= dlast.dvy;
    end
  end

  // velocity times approach time
  logic signed [62:0] m_mx_q, m_my_q;
  logic signed [63:0] m_dpx_q, m_dpy_q;
  logic [39:0]        m_t_q;
  logic               m_dvg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_mx_q  <= t_dvx_q * $signed({1'b0, t_q});
      m_my_q  <= t_dvy_q * $signed({1'b0, t_q});
      m_dpx_q <= t_dpx_q;
      m_dpy_q <= t_dpy_q;
      m_t_q   <= t_q;
      m_dvg_q <= t_dvg_q;
    end
  end

  // separation at approach time
  logic signed [63:0] a_x_q, a_y_q;
  logic [39:0]        a_t_q;
  logic               a_dvg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x_q   <= m_dpx_q + $signed({m_mx_q[62], m_mx_q});
      a_y_q   <= m_dpy_q + $signed({m_my_q[62], m_my_q});
      a_t_q   <= m_t_q;
      a_dvg_q <= m_dvg_q;
    end
  end

  // magnitudes
  logic [63:0] b_x_q, b_y_q;
  logic [39:0] b_t_q;
  logic        b_dvg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_x_q   <= a_x_q[63] ? 64'd0 - a_x_q : a_x_q;
      b_y_q   <= a_y_q[63] ? 64'd0 - a_y_q : a_y_q;
      b_t_q   <= a_t_q;
      b_dvg_q <= a_dvg_q;
    end
  end

  // square partial products
  logic [63:0] c_xll_q, c_xlh_q, c_xhh_q, c_yll_q, c_ylh_q, c_yhh_q;
  logic [39:0] c_t_q;
  logic        c_dvg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_xll_q <= b_x_q[31:0] * b_x_q[31:0];
      c_xlh_q <= b_x_q[31:0] * b_x_q[63:32];
      c_xhh_q <= b_x_q[63:32] * b_x_q[63:32];
      c_yll_q <= b_y_q[31:0] * b_y_q[31:0];
      c_ylh_q <= b_y_q[31:0] * b_y_q[63:32];
      c_yhh_q <= b_y_q[63:32] * b_y_q[63:32];
      c_t_q   <= b_t_q;
      c_dvg_q <= b_dvg_q;
    end
  end

  // squares per axis
  logic [127:0] s_x2_q, s_y2_q;
  logic [39:0]  s_t_q;
  logic         s_dvg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_x2_q  <= {c_xhh_q, 64'd0} + {31'd0, c_xlh_q, 33'd0} + {64'd0, c_xll_q};
      s_y2_q  <= {c_yhh_q, 64'd0} + {31'd0, c_ylh_q, 33'd0} + {64'd0, c_yll_q};
      s_t_q   <= c_t_q;
      s_dvg_q <= c_dvg_q;
    end
  end

  // square root pipeline, one bit per stage
  cpa_pkg::sqrt_t sq_q [cpa_pkg::SqrtSteps+1];
  cpa_pkg::sqrt_t sq_in;

  always_comb begin
    sq_in     = '0;
    sq_in.rad = s_x2_q + s_y2_q;
    sq_in.t   = s_t_q;
    sq_in.dvg = s_dvg_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq_in;
    end
  end

  for (genvar k = 1; k <= cpa_pkg::SqrtSteps; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k] <= cpa_pkg::sqrt_step(sq_q[k-1]);
      end
    end
  end

  // output: round to 1/256 m and saturate
  cpa_pkg::sqrt_t          slast;
  logic [64:0]             rnd;
  logic [40:0]             o_dist_q;
  logic [39:0]             o_t_q;
  logic                    o_dvg_q;

  assign slast = sq_q[cpa_pkg::SqrtSteps];
  assign rnd   = {1'b0, slast.root} + 65'd512;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_dist_q <= (rnd[64:10] > {14'd0, cpa_pkg::DistMax}) ? cpa_pkg::DistMax
                                                           : rnd[50:10];
      o_t_q    <= slast.t;
      o_dvg_q  <= slast.dvg;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {7'd0, o_dist_q, o_t_q};
  assign m_axis_tuser_o  = o_dvg_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      dv_v_q <= '0;
      vt_q   <= 1'b0;
      vm_q   <= 1'b0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vs_q   <= 1'b0;
      sq_v_q <= '0;
      vo_q   <= 1'b0;
    end else if (adv) begin
      v1_q   <= s_axis_tvalid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      dv_v_q <= {dv_v_q[cpa_pkg::DivSteps-1:0], v5_q};
      vt_q   <= dv_v_q[cpa_pkg::DivSteps];
      vm_q   <= vt_q;
      va_q   <= vm_q;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      vs_q   <= vc_q;
      sq_v_q <= {sq_v_q[cpa_pkg::SqrtSteps-1:0], vs_q};
      vo_q   <= sq_v_q[cpa_pkg::SqrtSteps];
    end
  end

`ifndef SYNTHESIS
  // a diverging pair always reports approach time zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[39:0] == '0)
    else $error("diverging item with nonzero time");

  // an overflowing quotient saturates the approach time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vt_q && t_go_q && t_ovf_q |-> t_q == cpa_pkg::TimeMax)
    else $error("approach time not saturated");

  // the input side stalls only while a result waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");
`endif

endmodule
